### sv/scfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfq_pkg
// Shared types and constants for the serial command framer queue.
// ----------------------------------------------------------------------------

package scfq_pkg;

	localparam logic [7:0] CHAR_CR = 8'h0D;
	localparam logic [7:0] CHAR_LF = 8'h0A;

	typedef struct packed {
		logic rx_en;
		logic pop_start;
		logic emit_load;
		logic empty_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic q_empty;
		logic last_char;
		logic out_free;
	} dp_stat_t;

endpackage

### sv/scfq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfq_ctrl
// Controller: input handshake and sequencing of pop readout.
// ----------------------------------------------------------------------------

module scfq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  scfq_pkg::dp_stat_t  stat,
	output scfq_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_EMIT  = 4'b0100,
		ST_EMPTY = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.rx_en     = accept && !action;
				cmd.pop_start = accept && action && !stat.q_empty;
				if (accept && action) begin
					state_nxt = stat.q_empty ? ST_EMPTY : ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit_load = stat.out_free;
				if (stat.out_free && stat.last_char) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				cmd.empty_load = stat.out_free;
				if (stat.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### sv/scfq_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfq_dp
// Datapath: command framing, queue storage and output register.
// ----------------------------------------------------------------------------

module scfq_dp #(
	parameter int BUF_LEN     = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  scfq_pkg::ctrl_cmd_t cmd,
	output scfq_pkg::dp_stat_t  stat,
	input  logic [7:0]          rx_byte,
	input  logic                out_stall,
	output logic                out_valid,
	output logic                cmd_valid,
	output logic [7:0]          command_id,
	output logic [7:0]          param_char,
	output logic                has_char,
	output logic                last,
	output logic [3:0]          remaining
);

	localparam int PMAX   = BUF_LEN - 1;
	localparam int LW     = $clog2(BUF_LEN);
	localparam int SLOTS  = QUEUE_DEPTH + 1;
	localparam int SW     = $clog2(SLOTS);
	localparam int CDEPTH = SLOTS * (2 ** LW);
	localparam int MW     = 8 + LW;

	logic [7:0]    char_mem [CDEPTH];
	logic [MW-1:0] meta_mem [SLOTS];

	logic          phase_q;
	logic [7:0]    pid_q;
	logic [LW-1:0] plen_q;
	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic [SW-1:0] count_q;
	logic [LW-1:0] idx_q;
	logic [7:0]    char_rd_q;
	logic [MW-1:0] meta_rd_q;
	logic          out_valid_q;

	logic          byte_live;
	logic          start_cmd;
	logic          take_char;
	logic          close_cmd;
	logic          enq;
	logic [SW-1:0] tail_nxt;
	logic [SW-1:0] head_nxt;
	logic [LW-1:0] rd_len;
	logic [7:0]    rd_id;
	logic [LW:0]   idx_inc;
	logic [LW-1:0] rd_idx;
	logic          last_char;
	logic          pop_done;
	logic [SW-1:0] rem;

	assign byte_live = cmd.rx_en && (rx_byte != scfq_pkg::CHAR_CR);
	assign start_cmd = byte_live && !phase_q;
	assign take_char = byte_live && phase_q && (rx_byte != scfq_pkg::CHAR_LF)
		&& (plen_q < LW'(PMAX));
	assign close_cmd = byte_live && phase_q && !take_char;
	assign enq       = close_cmd && (count_q != SW'(QUEUE_DEPTH));
	assign tail_nxt  = (tail_q == SW'(QUEUE_DEPTH)) ? '0 : tail_q + 1'b1;
	assign head_nxt  = (head_q == SW'(QUEUE_DEPTH)) ? '0 : head_q + 1'b1;

	assign rd_len    = meta_rd_q[LW-1:0];
	assign rd_id     = meta_rd_q[MW-1:LW];
	assign idx_inc   = {1'b0, idx_q} + (LW + 1)'(1);
	assign rd_idx    = cmd.emit_load ? idx_inc[LW-1:0] : idx_q;
	assign last_char = (rd_len == '0) || (idx_inc == {1'b0, rd_len});
	assign pop_done  = cmd.emit_load && last_char;
	assign rem       = count_q - 1'b1;

	assign stat.q_empty   = (count_q == '0);
	assign stat.last_char = last_char;
	assign stat.out_free  = !out_valid_q || !out_stall;

	// slot at tail is always free, parameter bytes go straight into it
	always_ff @(posedge clk) begin
		if (take_char) begin
			char_mem[{tail_q, plen_q}] <= rx_byte;
		end
		if (enq) begin
			meta_mem[tail_q] <= {pid_q, plen_q};
		end
		char_rd_q <= char_mem[{head_q, rd_idx}];
		meta_rd_q <= meta_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			pid_q   <= '0;
			plen_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (start_cmd) begin
				pid_q   <= rx_byte;
				plen_q  <= '0;
				phase_q <= 1'b1;
			end
			if (take_char) begin
				plen_q <= plen_q + 1'b1;
			end
			if (close_cmd) begin
				phase_q <= 1'b0;
			end
			if (enq) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + 1'b1;
			end
			if (cmd.pop_start) begin
				idx_q <= '0;
			end else if (cmd.emit_load) begin
				idx_q <= idx_inc[LW-1:0];
			end
			if (pop_done) begin
				head_q  <= head_nxt;
				count_q <= rem;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_load || cmd.empty_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			cmd_valid  <= 1'b1;
			command_id <= rd_id;
			param_char <= (rd_len == '0) ? 8'h00 : char_rd_q;
			has_char   <= (rd_len != '0);
			last       <= last_char;
			remaining  <= 4'(rem);
		end else if (cmd.empty_load) begin
			cmd_valid  <= 1'b0;
			command_id <= 8'h00;
			param_char <= 8'h00;
			has_char   <= 1'b0;
			last       <= 1'b1;
			remaining  <= 4'h0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### sv/serial_command_framer_queue.sv
`timescale 1ns / 1ps
// A received byte gives no result. A pop of a queued command passes through the FETCH and
// EMIT states before its first result is registered at the output; an empty-queue pop passes
// through EMPTY. Results then follow at one a cycle while the output is free.
// Bytes are taken one a cycle while no pop is in progress; in_stall is held after a pop is
// accepted until its last result is loaded into the output register.
// Reset: control and queue pointers clear at once; storage is not cleared.
// ----------------------------------------------------------------------------
// serial_command_framer_queue
// Frames serial bytes into commands, queues them and reads them out on pop.
// ----------------------------------------------------------------------------

module serial_command_framer_queue #(
	parameter int BUF_LEN     = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       cmd_valid,
	output logic [7:0] command_id,
	output logic [7:0] param_char,
	output logic       has_char,
	output logic       last,
	output logic [3:0] remaining
);

	scfq_pkg::ctrl_cmd_t cmd;
	scfq_pkg::dp_stat_t  stat;

	scfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.stat     (stat),
		.cmd      (cmd)
	);

	scfq_dp #(
		.BUF_LEN     (BUF_LEN),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.rx_byte    (rx_byte),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.cmd_valid  (cmd_valid),
		.command_id (command_id),
		.param_char (param_char),
		.has_char   (has_char),
		.last       (last),
		.remaining  (remaining)
	);

	a_pop_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && action |=> in_stall)
		else $error("input not held after pop item");

	a_empty_pop_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cmd_valid |-> last && !has_char)
		else $error("empty queue result malformed");

	a_no_char_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> last)
		else $error("empty parameter result not last");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid && $stable(command_id))
		else $error("pop readout broken");

endmodule
